// File: src/msc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_pkg
// Shared types and constants for the multipop stack with cost counter.
// ---------------------------------------------------------------------------
package msc_pkg;

    localparam int STACK_DEPTH = 16;                       // 2 .. 64
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int OPC_W       = 2;
    localparam int REQ_W       = 7;
    localparam int STAT_W      = 3;
    localparam int OCC_W       = 7;
    localparam int COST_W      = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_LIST = 2'd2
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_POPPED    = 3'd1,
        ST_LISTED    = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_NOOP      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [WORD_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

// File: src/msc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_if
// Valid/ready channels: command words in, result words out.
// ---------------------------------------------------------------------------
interface msc_cmd_if;
    import msc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic signed [WORD_W-1:0] push_value;
    logic [REQ_W-1:0]         pop_request;

    modport source (output valid, output opcode, output push_value, output pop_request,
                    input ready);
    modport sink   (input valid, input opcode, input push_value, input pop_request,
                    output ready);
endinterface

interface msc_res_if;
    import msc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] element;
    logic [STAT_W-1:0]        status;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
    logic [COST_W-1:0]        total_cost;

    modport source (output valid, output element, output status, output last,
                    output occupancy, output total_cost, input ready);
    modport sink   (input valid, input element, input status, input last,
                    input occupancy, input total_cost, output ready);
endinterface

// File: src/msc_stack_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_stack_mem
// Stack storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module msc_stack_mem (
    input  logic                              i_clk,
    input  msc_pkg::t_mem_wr                  i_wr,
    input  msc_pkg::t_mem_rd                  i_rd,
    output logic signed [msc_pkg::WORD_W-1:0] o_rd_data
);
    import msc_pkg::*;

    logic signed [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds while no read is issued (output stall)
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/multipop_stack_with_cost_count.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multipop_stack_with_cost_count
// Bounded LIFO of signed words with multipop, list and a saturating cost count.
// ---------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command word: push, multipop of pop_request words, or
//   list. o_res returns one result word per pushed, popped or listed element,
//   or a single overflow / underflow / no-op word; last marks the final word
//   of each command.
//   A push, overflow, underflow or no-op result is registered and valid in
//   the cycle after the command is accepted. Multipop and list read the
//   stack memory (registered read data), so the first element passes the
//   read data register and then the result register, then one element per
//   cycle while o_res is not stalled. A single-result command does not
//   hold off the next command; one that emits elements holds it off while the
//   single memory read port walks the stack one entry per cycle.
//   Reset (synchronous, active low) empties the stack and clears the cost;
//   stack memory contents are not cleared and need no clearing pass.
//   A stall on o_res holds the result register and freezes the walk; the
//   next command is taken in the cycle the last result leaves or as soon as
//   the result register is free.
// ---------------------------------------------------------------------------
module multipop_stack_with_cost_count (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msc_cmd_if.sink   i_cmd,
    msc_res_if.source o_res
);
    import msc_pkg::*;

    t_state                   r_state, n_state;
    logic [DEPTH_W-1:0]       r_depth, n_depth;
    logic [COST_W-1:0]        r_cost, n_cost;
    logic [ADDR_W-1:0]        r_ptr, n_ptr;
    logic [REQ_W-1:0]         r_remain, n_remain;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_elem, n_elem;
    t_status                  r_status, n_status;
    logic                     r_last, n_last;
    logic [OCC_W-1:0]         r_occ;
    logic [COST_W-1:0]        r_tot;

    t_mem_wr                  w_wr;
    t_mem_rd                  w_rd;
    logic signed [WORD_W-1:0] w_rd_data;

    logic                     w_slot_free;
    logic                     w_cmd_fire;
    logic                     w_empty;
    logic                     w_full;
    logic [ADDR_W-1:0]        w_top;
    logic                     w_pop_last;
    logic                     w_list_last;
    logic [COST_W-1:0]        w_cost_inc;
    logic                     w_out_load;

    msc_stack_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_slot_free;
    assign w_cmd_fire  = i_cmd.ready && i_cmd.valid;
    assign w_empty     = (r_depth == '0);
    assign w_full      = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign w_top       = ADDR_W'(r_depth - 1'b1);
    assign w_pop_last  = (r_remain == REQ_W'(1)) || (r_ptr == '0);
    assign w_list_last = (r_ptr == '0);
    assign w_cost_inc  = (r_cost == '1) ? r_cost : r_cost + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_cmd_fire && !w_empty) begin
                    if (i_cmd.opcode == OP_POP && i_cmd.pop_request != '0) begin
                        n_state = S_POP;
                    end else if (i_cmd.opcode == OP_LIST) begin
                        n_state = S_LIST;
                    end
                end
            end
            S_POP: begin
                if (w_slot_free && w_pop_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_slot_free && w_list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        w_out_load = 1'b0;
        n_elem     = '0;
        n_status   = ST_NOOP;
        n_last     = 1'b1;
        n_depth    = r_depth;
        n_cost     = r_cost;
        n_ptr      = r_ptr;
        n_remain   = r_remain;
        w_wr       = '0;
        w_rd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_cmd_fire) begin
                    case (i_cmd.opcode)
                        OP_PUSH: begin
                            w_out_load = 1'b1;
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                w_wr.en   = 1'b1;
                                w_wr.addr = ADDR_W'(r_depth);
                                w_wr.data = i_cmd.push_value;
                                n_depth   = r_depth + 1'b1;
                                n_cost    = w_cost_inc;
                                n_status  = ST_PUSHED;
                            end
                        end
                        OP_POP, OP_LIST: begin
                            if (w_empty) begin
                                w_out_load = 1'b1;
                                n_status   = ST_UNDERFLOW;
                            end else if (i_cmd.opcode == OP_POP && i_cmd.pop_request == '0) begin
                                w_out_load = 1'b1;
                                n_status   = ST_NOOP;
                            end else begin
                                w_rd.en   = 1'b1;
                                w_rd.addr = w_top;
                                n_ptr     = w_top;
                                n_remain  = i_cmd.pop_request;
                            end
                        end
                        default: begin
                            w_out_load = 1'b1;
                            n_status   = ST_NOOP;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_elem     = w_rd_data;
                    n_status   = ST_POPPED;
                    n_last     = w_pop_last;
                    n_depth    = DEPTH_W'(r_ptr);
                    n_cost     = w_cost_inc;
                    n_remain   = r_remain - 1'b1;
                    if (!w_pop_last) begin
                        w_rd.en   = 1'b1;
                        w_rd.addr = r_ptr - 1'b1;
                        n_ptr     = r_ptr - 1'b1;
                    end
                end
            end
            S_LIST: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_elem     = w_rd_data;
                    n_status   = ST_LISTED;
                    n_last     = w_list_last;
                    if (!w_list_last) begin
                        w_rd.en   = 1'b1;
                        w_rd.addr = r_ptr - 1'b1;
                        n_ptr     = r_ptr - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_cost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_cost  <= n_cost;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_remain <= n_remain;
        if (w_out_load) begin
            r_elem   <= n_elem;
            r_status <= n_status;
            r_last   <= n_last;
            r_occ    <= OCC_W'(n_depth);
            r_tot    <= n_cost;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.element    = r_elem;
    assign o_res.status     = r_status;
    assign o_res.last       = r_last;
    assign o_res.occupancy  = r_occ;
    assign o_res.total_cost = r_tot;

endmodule

// File: src/msc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_checker
// Port-level checks for the multipop stack, bound to the top level.
// ---------------------------------------------------------------------------
module msc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [msc_pkg::WORD_W-1:0]  i_res_element,
    input logic [msc_pkg::STAT_W-1:0]  i_res_status,
    input logic                        i_res_last,
    input logic [msc_pkg::OCC_W-1:0]   i_res_occupancy,
    input logic [msc_pkg::COST_W-1:0]  i_res_total_cost
);
    import msc_pkg::*;

    // no new command while a multi-word result is still in flight
    a_no_cmd_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_last) |-> !(i_cmd_valid && i_cmd_ready))
        else $error("command accepted before last result word");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_element) && $stable(i_res_status)
             && $stable(i_res_last) && $stable(i_res_total_cost)))
        else $error("result word changed under stall");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == ST_OVERFLOW) |->
            (i_res_occupancy == OCC_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    a_cost_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready) |=>
            (!i_res_valid || i_res_total_cost >= $past(i_res_total_cost)))
        else $error("total cost went backwards");

endmodule

bind multipop_stack_with_cost_count msc_checker u_msc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_element    (o_res.element),
    .i_res_status     (o_res.status),
    .i_res_last       (o_res.last),
    .i_res_occupancy  (o_res.occupancy),
    .i_res_total_cost (o_res.total_cost)
);

// File: sim/tb_multipop_stack_with_cost_count.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multipop_stack_with_cost_count
// Self-checking bench: a short directed table (empty, full, no-op and unused
// opcode cases, extreme words and pop counts), then random command mixes.
// A shadow stack predicts each result word, compared in order on o_res.
// ---------------------------------------------------------------------------
module tb_multipop_stack_with_cost_count;
    import msc_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED   = 2'd3;
    localparam int               STALL_LIMIT = 1000;
    localparam int               HOLD_CYCLES = 120;
    localparam int               RAND_PER_PH = 44;
    localparam int               N_DIRECTED  = 14;

    typedef struct {
        logic signed [WORD_W-1:0] element;
        t_status                  status;
        logic                     last;
        logic [OCC_W-1:0]         occupancy;
        logic [COST_W-1:0]        total_cost;
    } t_res_word;

    typedef struct {
        logic [OPC_W-1:0]         opcode;
        logic signed [WORD_W-1:0] value;
        logic [REQ_W-1:0]         req;
        int                       reps;
        bit                       typed;
        t_status                  status;
        logic [OCC_W-1:0]         occ;
        logic [COST_W-1:0]        cost;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    msc_cmd_if cmd_ch();
    msc_res_if res_ch();

    multipop_stack_with_cost_count u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the stack
    logic signed [WORD_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned              shadow_depth;
    logic [COST_W-1:0]        shadow_cost;

    t_res_word pending_results [$];
    int        mismatches;
    int        src_idle_pct;
    int        snk_idle_pct;
    int        holds_asked;
    t_dir_row  directed_rows [N_DIRECTED];

    function automatic t_res_word shadow_word(input logic signed [WORD_W-1:0] elem,
                                              input t_status st, input logic is_last);
        t_res_word w;
        w.element    = elem;
        w.status     = st;
        w.last       = is_last;
        w.occupancy  = OCC_W'(shadow_depth);
        w.total_cost = shadow_cost;
        return w;
    endfunction

    task automatic predict_cmd(input logic [OPC_W-1:0] op,
                               input logic signed [WORD_W-1:0] val,
                               input logic [REQ_W-1:0] req, ref t_res_word outq[$]);
        int unsigned left;
        outq.delete();
        case (op)
            OP_PUSH: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    outq.push_back(shadow_word('0, ST_OVERFLOW, 1'b1));
                end else begin
                    shadow_stack[shadow_depth] = val;
                    shadow_depth++;
                    if (shadow_cost != '1) shadow_cost++;
                    outq.push_back(shadow_word('0, ST_PUSHED, 1'b1));
                end
            end
            OP_POP: begin
                if (shadow_depth == 0) begin
                    outq.push_back(shadow_word('0, ST_UNDERFLOW, 1'b1));
                end else if (req == 0) begin
                    outq.push_back(shadow_word('0, ST_NOOP, 1'b1));
                end else begin
                    left = req;
                    // stops early once the stack runs dry
                    while (left > 0 && shadow_depth > 0) begin
                        shadow_depth--;
                        left--;
                        if (shadow_cost != '1) shadow_cost++;
                        outq.push_back(shadow_word(shadow_stack[shadow_depth], ST_POPPED,
                                                   left == 0 || shadow_depth == 0));
                    end
                end
            end
            OP_LIST: begin
                if (shadow_depth == 0) begin
                    outq.push_back(shadow_word('0, ST_UNDERFLOW, 1'b1));
                end else begin
                    for (int i = shadow_depth; i > 0; i--)
                        outq.push_back(shadow_word(shadow_stack[i-1], ST_LISTED, i == 1));
                end
            end
            default: begin
                outq.push_back(shadow_word('0, ST_NOOP, 1'b1));
            end
        endcase
    endtask

    // Predict, queue the expected words, then offer the command word until taken.
    task automatic issue_cmd(input logic [OPC_W-1:0] op, input logic signed [WORD_W-1:0] val,
                             input logic [REQ_W-1:0] req, input bit typed,
                             input t_res_word typed_word);
        t_res_word outq [$];
        predict_cmd(op, val, req, outq);
        if (typed) outq = '{typed_word};
        foreach (outq[i]) pending_results.push_back(outq[i]);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.push_value  <= val;
        cmd_ch.pop_request <= req;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // result side: random stalls, one long hold on request, in-order check
    initial begin : result_sink
        t_res_word want;
        int        hold_left;
        int        holds_done;
        hold_left  = 0;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word elem=%h st=%0d last=%b occ=%0d cost=%h",
                                 $realtime, res_ch.element, res_ch.status, res_ch.last,
                                 res_ch.occupancy, res_ch.total_cost);
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.element !== want.element || res_ch.status !== want.status ||
                        res_ch.last !== want.last || res_ch.occupancy !== want.occupancy ||
                        res_ch.total_cost !== want.total_cost) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp elem=%h st=%0d last=%b occ=%0d ",
                                      "cost=%h, got elem=%h st=%0d last=%b occ=%0d cost=%h"},
                                     $realtime, want.element, want.status, want.last,
                                     want.occupancy, want.total_cost, res_ch.element,
                                     res_ch.status, res_ch.last, res_ch.occupancy,
                                     res_ch.total_cost);
                    end
                end
            end
            if (holds_done != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_res_word                typed_word;
        t_res_word                no_word;
        logic [OPC_W-1:0]         op;
        logic signed [WORD_W-1:0] val;
        logic [REQ_W-1:0]         req;
        int                       push_pct;
        int                       pick;

        mismatches   = 0;
        shadow_depth = 0;
        shadow_cost  = '0;
        src_idle_pct = 33;
        snk_idle_pct <= 55;
        holds_asked  <= 0;
        i_rst_n            <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= OP_PUSH;
        cmd_ch.push_value  <= '0;
        cmd_ch.pop_request <= '0;

        directed_rows = '{
            '{OP_POP,    32'sd0,           7'd5,   1,  1'b1, ST_UNDERFLOW, 7'd0,  32'd0},
            '{OP_LIST,   32'sd0,           7'd0,   1,  1'b1, ST_UNDERFLOW, 7'd0,  32'd0},
            '{OP_UNUSED, 32'sd0,           7'd0,   1,  1'b1, ST_NOOP,      7'd0,  32'd0},
            '{OP_PUSH,   32'sh8000_0000,   7'd0,   1,  1'b1, ST_PUSHED,    7'd1,  32'd1},
            '{OP_PUSH,   32'sh7FFF_FFFF,   7'd127, 1,  1'b1, ST_PUSHED,    7'd2,  32'd2},
            '{OP_POP,    32'sd0,           7'd0,   1,  1'b1, ST_NOOP,      7'd2,  32'd2},
            '{OP_LIST,   32'sd0,           7'd0,   1,  1'b0, ST_NOOP,      7'd0,  32'd0},
            '{OP_PUSH,   -32'sd7,          7'd0,   14, 1'b0, ST_NOOP,      7'd0,  32'd0},
            '{OP_PUSH,   32'sh5555_AAAA,   7'd0,   1,  1'b1, ST_OVERFLOW,  7'd16, 32'd16},
            '{OP_LIST,   32'sd0,           7'd0,   1,  1'b0, ST_NOOP,      7'd0,  32'd0},
            '{OP_UNUSED, 32'shFFFF_FFFF,   7'd127, 1,  1'b1, ST_NOOP,      7'd16, 32'd16},
            '{OP_POP,    32'sd0,           7'd3,   1,  1'b0, ST_NOOP,      7'd0,  32'd0},
            '{OP_POP,    32'sd0,           7'd127, 1,  1'b0, ST_NOOP,      7'd0,  32'd0},
            '{OP_POP,    32'sd0,           7'd64,  1,  1'b1, ST_UNDERFLOW, 7'd0,  32'd32}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            typed_word = '{'0, directed_rows[r].status, 1'b1,
                           directed_rows[r].occ, directed_rows[r].cost};
            for (int k = 0; k < directed_rows[r].reps; k++)
                issue_cmd(directed_rows[r].opcode, directed_rows[r].value + k,
                          directed_rows[r].req, directed_rows[r].typed, typed_word);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 33;
                    snk_idle_pct <= 55;
                end
                1: begin
                    src_idle_pct = 55;
                    snk_idle_pct <= 33;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct <= 0;
                    holds_asked  <= holds_asked + 1;   // long stall, stack side backs up
                end
            endcase
            push_pct = 50;
            for (int n = 0; n < RAND_PER_PH; n++) begin
                // shift the push/pop balance now and then to reach full and empty
                if (n % 18 == 0) begin
                    pick = $urandom_range(2);
                    push_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
                end
                val  = $urandom;
                req  = '0;
                pick = $urandom_range(99);
                if (pick < push_pct) begin
                    op = OP_PUSH;
                end else begin
                    pick = $urandom_range(99);
                    op   = (pick < 60) ? OP_POP : (pick < 90) ? OP_LIST : OP_UNUSED;
                    pick = $urandom_range(9);
                    if (pick == 0)
                        req = '0;
                    else if (pick < 7)
                        req = REQ_W'($urandom_range(4, 1));
                    else if (pick < 9)
                        req = REQ_W'($urandom_range(20, 5));
                    else
                        req = REQ_W'($urandom_range(127, 21));
                end
                issue_cmd(op, val, req, 1'b0, no_word);
            end
        end
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
